// ===== rtl/lr35902_pkg.sv =====
// Shared types, instruction classes and helpers for the LR35902 execute unit.
`timescale 1ns / 1ps
`default_nettype none
package lr35902_pkg;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 144;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_BYTE = 2'd1,
    WK_WORD = 2'd2
  } write_kind_t;

  // Instruction class worked out by the front end.
  typedef enum logic [4:0] {
    CL_NOP,
    CL_UNSUP,
    CL_LD_NN_SP,
    CL_JR,
    CL_ADD_HL,
    CL_LD_RR_NN,
    CL_LD_IND_A,
    CL_LD_A_IND,
    CL_INCDEC16,
    CL_INC8,
    CL_DEC8,
    CL_LD_R_N,
    CL_ROT,
    CL_LD_R_R,
    CL_ALU
  } op_class_t;

  typedef struct packed {
    op_class_t  cls;
    logic [7:0] opcode;
    logic [15:0] imm;
    logic [7:0] mem_data;
  } dec_word_t;

  typedef struct packed {
    logic [4:0]  cycle_count;
    logic [15:0] write_data;
    logic [15:0] write_address;
    logic [1:0]  write_kind;
    logic [15:0] reg_sp;
    logic [15:0] reg_hl;
    logic [15:0] reg_de;
    logic [15:0] reg_bc;
    logic [15:0] reg_af;
    logic [15:0] pc_out;
  } res_word_t;

  function automatic op_class_t classify(input logic [7:0] op);
    op_class_t c;
    c = CL_NOP;
    if (op > 8'h98 || op == 8'h10 || op == 8'h27 || op == 8'h76) begin
      c = CL_UNSUP;
    end else if (op < 8'h40) begin
      unique case (op[2:0])
        3'd0: begin
          if (op == 8'h08) c = CL_LD_NN_SP;
          else if (op >= 8'h18) c = CL_JR;
          else c = CL_NOP;
        end
        3'd1: c = op[3] ? CL_ADD_HL : CL_LD_RR_NN;
        3'd2: c = op[3] ? CL_LD_A_IND : CL_LD_IND_A;
        3'd3: c = CL_INCDEC16;
        3'd4: c = CL_INC8;
        3'd5: c = CL_DEC8;
        3'd6: c = CL_LD_R_N;
        default: c = CL_ROT;
      endcase
    end else if (op < 8'h80) begin
      c = CL_LD_R_R;
    end else begin
      c = CL_ALU;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lr35902_front.sv =====
// Front end: accepts instruction words and classifies the opcode.
`timescale 1ns / 1ps
`default_nettype none
module lr35902_front
  import lr35902_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_word,
  output logic             dec_valid,
  input  wire logic        dec_ready,
  output dec_word_t        dec_word
);

  logic      valid_r, valid_nxt;
  dec_word_t word_r;

  assign in_ready  = !valid_r || dec_ready;
  assign dec_valid = valid_r;
  assign dec_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      word_r.cls      <= classify(in_word[7:0]);
      word_r.opcode   <= in_word[7:0];
      word_r.imm      <= in_word[23:8];
      word_r.mem_data <= in_word[31:24];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lr35902_queue.sv =====
// Two-entry queue between the decode front and the execute back end.
`timescale 1ns / 1ps
`default_nettype none
module lr35902_queue
  import lr35902_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  dec_word_t  wr_word,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output dec_word_t  rd_word
);

  dec_word_t   mem_r [QDepth];
  logic        wptr_r, rptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        do_wr, do_rd;

  assign wr_ready = count_r != 2'(QDepth);
  assign rd_valid = count_r != 2'd0;
  assign rd_word  = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 2'd1;
    else if (!do_wr && do_rd) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) wptr_r <= !wptr_r;
      if (do_rd) rptr_r <= !rptr_r;
    end
    if (do_wr) mem_r[wptr_r] <= wr_word;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(QDepth)) else $error("queue overfilled");
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'(QDepth) && !do_rd) |=> count_r == 2'(QDepth))
    else $error("full queue lost a word");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd0 |-> wptr_r == rptr_r) else $error("pointers disagree on empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/lr35902_back.sv =====
// Back end: executes one classified instruction per cycle on the register file while out_ready allows.
`timescale 1ns / 1ps
`default_nettype none
module lr35902_back
  import lr35902_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  ex_valid,
  output logic       ex_ready,
  input  dec_word_t  ex_word,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_word_t  res,
  output logic       res_status
);

  logic [7:0]  a_r, a_nxt;
  logic [3:0]  f_r, f_nxt;
  logic [15:0] bc_r, bc_nxt, de_r, de_nxt, hl_r, hl_nxt, sp_r, sp_nxt, pc_r, pc_nxt;
  logic        valid_r;
  res_word_t   res_r, res_nxt;
  logic        st_r, st_nxt;
  logic        fire;

  logic [7:0]  op, n8, md, src8, r8;
  logic [2:0]  hi, lo;
  logic [1:0]  pr;
  logic [15:0] rr, addr, disp;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [8:0]  r9;
  logic [4:0]  h5;
  logic        cin, take;
  logic [1:0]  wk;
  logic [15:0] wa, wd;
  logic [4:0]  cyc;

  assign ex_ready   = !valid_r || out_ready;
  assign fire       = ex_valid && ex_ready;
  assign out_valid  = valid_r;
  assign res        = res_r;
  assign res_status = st_r;

  function automatic logic [7:0] get8(input logic [2:0] k, input logic [15:0] bc,
      input logic [15:0] de, input logic [15:0] hl, input logic [7:0] m,
      input logic [7:0] a);
    logic [7:0] v;
    unique case (k)
      3'd0: v = bc[15:8];
      3'd1: v = bc[7:0];
      3'd2: v = de[15:8];
      3'd3: v = de[7:0];
      3'd4: v = hl[15:8];
      3'd5: v = hl[7:0];
      3'd6: v = m;
      default: v = a;
    endcase
    return v;
  endfunction

  always_comb begin
    op = ex_word.opcode;
    n8 = ex_word.imm[7:0];
    md = ex_word.mem_data;
    hi = op[5:3];
    lo = op[2:0];
    pr = op[5:4];
    a_nxt = a_r; f_nxt = f_r; bc_nxt = bc_r; de_nxt = de_r; hl_nxt = hl_r;
    sp_nxt = sp_r;
    pc_nxt = pc_r + 16'd1;
    wk = WK_NONE; wa = 16'd0; wd = 16'd0; cyc = 5'd4; st_nxt = 1'b0;
    unique case (pr)
      2'd0: rr = bc_r;
      2'd1: rr = de_r;
      2'd2: rr = hl_r;
      default: rr = sp_r;
    endcase
    addr = (pr == 2'd0) ? bc_r : (pr == 2'd1) ? de_r : hl_r;
    src8 = get8(ex_word.cls == CL_INC8 || ex_word.cls == CL_DEC8 ? hi : lo,
                bc_r, de_r, hl_r, md, a_r);
    r8 = 8'd0; sum17 = 17'd0; sum13 = 13'd0; r9 = 9'd0; h5 = 5'd0;
    cin = 1'b0; take = 1'b1;
    disp = {{8{n8[7]}}, n8};
    unique case (ex_word.cls)
      CL_UNSUP: st_nxt = 1'b1;
      CL_NOP: ;
      CL_LD_NN_SP: begin
        wk = WK_WORD; wa = ex_word.imm; wd = sp_r;
        pc_nxt = pc_r + 16'd3; cyc = 5'd20;
      end
      CL_JR: begin
        priority case (op)
          8'h20: take = !f_r[3];
          8'h28: take = f_r[3];
          8'h30: take = !f_r[0];
          8'h38: take = f_r[0];
          default: take = 1'b1;
        endcase
        pc_nxt = pc_r + 16'd2 + (take ? disp : 16'd0);
        cyc = take ? 5'd12 : 5'd8;
      end
      CL_ADD_HL: begin
        sum17 = {1'b0, hl_r} + {1'b0, rr};
        sum13 = {1'b0, hl_r[11:0]} + {1'b0, rr[11:0]};
        f_nxt = {f_r[3], 1'b0, sum13[12], sum17[16]};
        hl_nxt = sum17[15:0];
        cyc = 5'd8;
      end
      CL_LD_RR_NN: begin
        unique case (pr)
          2'd0: bc_nxt = ex_word.imm;
          2'd1: de_nxt = ex_word.imm;
          2'd2: hl_nxt = ex_word.imm;
          default: sp_nxt = ex_word.imm;
        endcase
        pc_nxt = pc_r + 16'd3; cyc = 5'd12;
      end
      CL_LD_IND_A, CL_LD_A_IND: begin
        if (ex_word.cls == CL_LD_A_IND) a_nxt = md;
        else begin
          wk = WK_BYTE; wa = addr; wd = {8'd0, a_r};
        end
        if (pr == 2'd2) hl_nxt = hl_r + 16'd1;
        if (pr == 2'd3) hl_nxt = hl_r - 16'd1;
        cyc = 5'd8;
      end
      CL_INCDEC16: begin
        rr = rr + (op[3] ? 16'hFFFF : 16'd1);
        unique case (pr)
          2'd0: bc_nxt = rr;
          2'd1: de_nxt = rr;
          2'd2: hl_nxt = rr;
          default: sp_nxt = rr;
        endcase
        cyc = 5'd8;
      end
      CL_INC8, CL_DEC8, CL_LD_R_N, CL_LD_R_R: begin
        if (ex_word.cls == CL_INC8) begin
          r8 = src8 + 8'd1;
          f_nxt = {r8 == 8'd0, 1'b0, src8[3:0] == 4'hF, f_r[0]};
        end else if (ex_word.cls == CL_DEC8) begin
          r8 = src8 - 8'd1;
          f_nxt = {r8 == 8'd0, 1'b1, src8[3:0] == 4'h0, f_r[0]};
        end else if (ex_word.cls == CL_LD_R_N) begin
          r8 = n8;
          pc_nxt = pc_r + 16'd2;
        end else begin
          r8 = src8;
        end
        if (ex_word.cls == CL_LD_R_R) cyc = (lo == 3'd6) ? 5'd8 : 5'd4;
        else if (ex_word.cls == CL_LD_R_N) cyc = (hi == 3'd6) ? 5'd12 : 5'd8;
        else cyc = (hi == 3'd6) ? 5'd12 : 5'd4;
        if (hi == 3'd6) begin
          wk = WK_BYTE; wa = hl_r; wd = {8'd0, r8};
          if (ex_word.cls == CL_LD_R_R) cyc = 5'd8;
        end else begin
          unique case (hi)
            3'd0: bc_nxt[15:8] = r8;
            3'd1: bc_nxt[7:0] = r8;
            3'd2: de_nxt[15:8] = r8;
            3'd3: de_nxt[7:0] = r8;
            3'd4: hl_nxt[15:8] = r8;
            3'd5: hl_nxt[7:0] = r8;
            default: a_nxt = r8;
          endcase
        end
      end
      CL_ROT: begin
        unique case (hi)
          3'd0: begin a_nxt = {a_r[6:0], a_r[7]}; f_nxt = {3'b000, a_r[7]}; end
          3'd1: begin a_nxt = {a_r[0], a_r[7:1]}; f_nxt = {3'b000, a_r[0]}; end
          3'd2: begin a_nxt = {a_r[6:0], f_r[0]}; f_nxt = {3'b000, a_r[7]}; end
          3'd3: begin a_nxt = {f_r[0], a_r[7:1]}; f_nxt = {3'b000, a_r[0]}; end
          3'd5: begin a_nxt = ~a_r; f_nxt = f_r | 4'b0110; end
          3'd6: f_nxt = {f_r[3], 3'b001};
          default: f_nxt = {f_r[3], 2'b00, !f_r[0]};
        endcase
      end
      CL_ALU: begin
        cin = hi[0] & f_r[0];
        if (!hi[1]) begin
          r9 = {1'b0, a_r} + {1'b0, src8} + {8'd0, cin};
          h5 = {1'b0, a_r[3:0]} + {1'b0, src8[3:0]} + {4'd0, cin};
          f_nxt = {r9[7:0] == 8'd0, 1'b0, h5[4], r9[8]};
        end else begin
          r9 = {1'b0, a_r} - {1'b0, src8} - {8'd0, cin};
          h5 = {1'b0, a_r[3:0]} - {1'b0, src8[3:0]} - {4'd0, cin};
          f_nxt = {r9[7:0] == 8'd0, 1'b1, h5[4], r9[8]};
        end
        a_nxt = r9[7:0];
        cyc = (lo == 3'd6) ? 5'd8 : 5'd4;
      end
      default: ;
    endcase
    res_nxt.pc_out        = pc_nxt;
    res_nxt.reg_af        = {a_nxt, f_nxt, 4'd0};
    res_nxt.reg_bc        = bc_nxt;
    res_nxt.reg_de        = de_nxt;
    res_nxt.reg_hl        = hl_nxt;
    res_nxt.reg_sp        = sp_nxt;
    res_nxt.write_kind    = wk;
    res_nxt.write_address = wa;
    res_nxt.write_data    = wd;
    res_nxt.cycle_count   = cyc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      a_r <= 8'd0; f_r <= 4'd0; bc_r <= 16'd0; de_r <= 16'd0; hl_r <= 16'd0;
      sp_r <= 16'd0; pc_r <= 16'd0;
    end else begin
      if (ex_ready) valid_r <= ex_valid;
      if (fire) begin
        a_r <= a_nxt; f_r <= f_nxt; bc_r <= bc_nxt; de_r <= de_nxt;
        hl_r <= hl_nxt; sp_r <= sp_nxt; pc_r <= pc_nxt;
      end
    end
    if (fire) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> res_r.pc_out == pc_r) else $error("result pc and state pc differ");
  a_unsup_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && st_r) |-> (res_r.cycle_count == 5'd4 && res_r.write_kind == WK_NONE))
    else $error("unsupported opcode did work");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> $stable(pc_r)) else $error("state moved on stall");
`endif

endmodule
`default_nettype wire

// ===== rtl/lr35902_instruction_execute_unit.sv =====
// Top level of the LR35902 instruction execute unit.
// A word passes the decode register, the queue and the execute register on its way
// from in_* to out_*. Throughput: one instruction per cycle while out_tready allows,
// set by the execute stage that updates the register file.
// Reset: rst_n synchronous, active low; clears all CPU registers and empties the pipe.
`timescale 1ns / 1ps
`default_nettype none
module lr35902_instruction_execute_unit
  import lr35902_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode[7:0], immediate[23:8], mem_data[31:24]
  input  wire logic [31:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pc_out, reg_af, reg_bc, reg_de, reg_hl, reg_sp, write_kind, write_address,
  // write_data, cycle_count, status from bit 0 up, zero padded
  output logic [143:0]      out_tdata
);

  logic      f_valid, f_ready, q_valid, q_ready, st;
  dec_word_t f_word, q_word;
  res_word_t r;

  lr35902_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_word(in_tdata),
    .dec_valid(f_valid), .dec_ready(f_ready), .dec_word(f_word)
  );

  lr35902_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_word(f_word),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word)
  );

  lr35902_back u_back (
    .clk, .rst_n, .ex_valid(q_valid), .ex_ready(q_ready), .ex_word(q_word),
    .out_valid(out_tvalid), .out_ready(out_tready), .res(r), .res_status(st)
  );

  assign out_tdata = {8'd0, st, r.cycle_count, r.write_data, r.write_address,
                      r.write_kind, r.reg_sp, r.reg_hl, r.reg_de, r.reg_bc,
                      r.reg_af, r.pc_out};

endmodule
`default_nettype wire

// ===== tb/sv/tb_lr35902_instruction_execute_unit.sv =====
// Self-checking testbench for the LR35902 instruction execute unit.
`timescale 1ns / 1ps
module tb_lr35902_instruction_execute_unit;
  import lr35902_pkg::*;

  localparam logic [3:0] FZ = 4'h8;
  localparam logic [3:0] FN = 4'h4;
  localparam logic [3:0] FH = 4'h2;
  localparam logic [3:0] FC = 4'h1;
  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_LD_NN_SP = 8'h08;
  localparam logic [7:0] OP_STOP = 8'h10;
  localparam logic [7:0] OP_JR = 8'h18;
  localparam logic [7:0] OP_JR_NZ = 8'h20;
  localparam logic [7:0] OP_JR_Z = 8'h28;
  localparam logic [7:0] OP_JR_NC = 8'h30;
  localparam logic [7:0] OP_JR_C = 8'h38;
  localparam logic [7:0] OP_DAA = 8'h27;
  localparam logic [7:0] OP_HALT = 8'h76;
  localparam logic [7:0] OP_RLCA = 8'h07;
  localparam logic [7:0] OP_RRCA = 8'h0F;
  localparam logic [7:0] OP_RLA = 8'h17;
  localparam logic [7:0] OP_RRA = 8'h1F;
  localparam logic [7:0] OP_CPL = 8'h2F;
  localparam logic [7:0] OP_SCF = 8'h37;
  localparam logic [7:0] OP_LAST = 8'h98;

  typedef struct packed {
    logic        status;
    logic [4:0]  cycles;
    logic [15:0] wdata;
    logic [15:0] waddr;
    logic [1:0]  wkind;
    logic [15:0] sp;
    logic [15:0] hl;
    logic [15:0] de;
    logic [15:0] bc;
    logic [15:0] af;
    logic [15:0] pc;
  } cpu_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [143:0] out_tdata;

  lr35902_instruction_execute_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted CPU state, matching the state after reset.
  logic [7:0] m_a = '0;
  logic [3:0] m_f = '0;
  logic [15:0] m_bc = '0, m_de = '0, m_hl = '0, m_sp = '0, m_pc = '0;

  cpu_word_t expected_words[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  function automatic logic [15:0] pair_get(input logic [1:0] k);
    case (k)
      2'd0: return m_bc;
      2'd1: return m_de;
      2'd2: return m_hl;
      default: return m_sp;
    endcase
  endfunction

  function automatic void pair_set(input logic [1:0] k, input logic [15:0] v);
    case (k)
      2'd0: m_bc = v;
      2'd1: m_de = v;
      2'd2: m_hl = v;
      default: m_sp = v;
    endcase
  endfunction

  function automatic logic [7:0] reg_get(input logic [2:0] k, input logic [7:0] md);
    case (k)
      3'd0: return m_bc[15:8];
      3'd1: return m_bc[7:0];
      3'd2: return m_de[15:8];
      3'd3: return m_de[7:0];
      3'd4: return m_hl[15:8];
      3'd5: return m_hl[7:0];
      3'd6: return md;
      default: return m_a;
    endcase
  endfunction

  function automatic void reg_set(input logic [2:0] k, input logic [7:0] v);
    case (k)
      3'd0: m_bc[15:8] = v;
      3'd1: m_bc[7:0] = v;
      3'd2: m_de[15:8] = v;
      3'd3: m_de[7:0] = v;
      3'd4: m_hl[15:8] = v;
      3'd5: m_hl[7:0] = v;
      3'd6: ;
      default: m_a = v;
    endcase
  endfunction

  // Executes one instruction on the predicted state and returns the result word.
  function automatic cpu_word_t execute_instr(input logic [7:0] op, input logic [15:0] imm,
                                              input logic [7:0] md);
    cpu_word_t w;
    logic [15:0] nxt, addr, s16;
    logic [2:0] hi, lo;
    logic [1:0] pr;
    logic [7:0] v, n8, a;
    logic take, c;
    logic [16:0] sum;
    logic [8:0] r9;
    logic [4:0] h5;
    w = '0;
    hi = op[5:3];
    lo = op[2:0];
    pr = op[5:4];
    n8 = imm[7:0];
    nxt = m_pc + 16'd1;
    w.cycles = 5'd4;
    if (op > OP_LAST || op == OP_STOP || op == OP_DAA || op == OP_HALT) begin
      w.status = 1'b1;
    end else if (op < 8'h40) begin
      case (lo)
        3'd0: begin
          if (op == OP_LD_NN_SP) begin
            w.wkind = WK_WORD; w.waddr = imm; w.wdata = m_sp;
            nxt = m_pc + 16'd3; w.cycles = 5'd20;
          end else if (op >= OP_JR) begin
            nxt = m_pc + 16'd2;
            take = 1'b1;
            if (op == OP_JR_NZ) take = !m_f[3];
            else if (op == OP_JR_Z) take = m_f[3];
            else if (op == OP_JR_NC) take = !m_f[0];
            else if (op == OP_JR_C) take = m_f[0];
            w.cycles = 5'd8;
            if (take) begin
              nxt = nxt + {{8{n8[7]}}, n8};
              w.cycles = 5'd12;
            end
          end
        end
        3'd1: begin
          if (op[3]) begin
            s16 = pair_get(pr);
            sum = {1'b0, m_hl} + {1'b0, s16};
            m_f = (m_f & FZ) | (({1'b0, m_hl[11:0]} + {1'b0, s16[11:0]}) > 13'hFFF
                                ? FH : 4'h0) | (sum[16] ? FC : 4'h0);
            m_hl = sum[15:0];
            w.cycles = 5'd8;
          end else begin
            pair_set(pr, imm);
            nxt = m_pc + 16'd3; w.cycles = 5'd12;
          end
        end
        3'd2: begin
          addr = (pr == 2'd0) ? m_bc : (pr == 2'd1) ? m_de : m_hl;
          if (op[3]) m_a = md;
          else begin
            w.wkind = WK_BYTE; w.waddr = addr; w.wdata = {8'h00, m_a};
          end
          if (pr == 2'd2) m_hl = m_hl + 16'd1;
          if (pr == 2'd3) m_hl = m_hl - 16'd1;
          w.cycles = 5'd8;
        end
        3'd3: begin
          pair_set(pr, pair_get(pr) + (op[3] ? 16'hFFFF : 16'h0001));
          w.cycles = 5'd8;
        end
        3'd4, 3'd5: begin
          v = reg_get(hi, md);
          if (lo == 3'd4) begin
            m_f = (m_f & FC) | ((v[3:0] == 4'hF) ? FH : 4'h0);
            v = v + 8'd1;
          end else begin
            m_f = (m_f & FC) | FN | ((v[3:0] == 4'h0) ? FH : 4'h0);
            v = v - 8'd1;
          end
          if (v == 8'h00) m_f = m_f | FZ;
          if (hi == 3'd6) begin
            w.wkind = WK_BYTE; w.waddr = m_hl; w.wdata = {8'h00, v}; w.cycles = 5'd12;
          end else reg_set(hi, v);
        end
        3'd6: begin
          nxt = m_pc + 16'd2;
          if (hi == 3'd6) begin
            w.wkind = WK_BYTE; w.waddr = m_hl; w.wdata = {8'h00, n8}; w.cycles = 5'd12;
          end else begin
            reg_set(hi, n8); w.cycles = 5'd8;
          end
        end
        default: begin
          a = m_a;
          c = m_f[0];
          case (op)
            OP_RLCA: begin m_f = {3'b000, a[7]}; a = {a[6:0], a[7]}; end
            OP_RRCA: begin m_f = {3'b000, a[0]}; a = {a[0], a[7:1]}; end
            OP_RLA: begin m_f = {3'b000, a[7]}; a = {a[6:0], c}; end
            OP_RRA: begin m_f = {3'b000, a[0]}; a = {c, a[7:1]}; end
            OP_CPL: begin a = ~a; m_f = m_f | FN | FH; end
            OP_SCF: m_f = (m_f & FZ) | FC;
            default: m_f = (m_f & FZ) | {3'b000, ~c};
          endcase
          m_a = a;
        end
      endcase
    end else if (op < 8'h80) begin
      v = reg_get(lo, md);
      if (lo == 3'd6) w.cycles = 5'd8;
      if (hi == 3'd6) begin
        w.wkind = WK_BYTE; w.waddr = m_hl; w.wdata = {8'h00, v}; w.cycles = 5'd8;
      end else reg_set(hi, v);
    end else begin
      v = reg_get(lo, md);
      c = hi[0] ? m_f[0] : 1'b0;
      if (!hi[1]) begin
        r9 = {1'b0, m_a} + {1'b0, v} + c;
        h5 = {1'b0, m_a[3:0]} + {1'b0, v[3:0]} + c;
        m_f = (h5 > 5'h0F ? FH : 4'h0) | (r9[8] ? FC : 4'h0);
      end else begin
        r9 = {1'b0, m_a} - {1'b0, v} - c;
        m_f = FN | (({1'b0, m_a[3:0]} < {1'b0, v[3:0]} + c) ? FH : 4'h0)
                 | (({1'b0, m_a} < {1'b0, v} + c) ? FC : 4'h0);
      end
      m_a = r9[7:0];
      if (m_a == 8'h00) m_f = m_f | FZ;
      if (lo == 3'd6) w.cycles = 5'd8;
    end
    m_pc = nxt;
    w.pc = m_pc;
    w.af = {m_a, m_f, 4'h0};
    w.bc = m_bc;
    w.de = m_de;
    w.hl = m_hl;
    w.sp = m_sp;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("ERROR word %0d: %s got %h expected %h", n_checked, what, got, want);
  endtask

  // Valid stays high after a handshake so that words can follow back to back;
  // it drops only while the sender idles or waits.
  task automatic send_instr(input logic [7:0] op, input logic [15:0] imm, input logic [7:0] md);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected_words.push_back(execute_instr(op, imm, md));
    in_tvalid <= 1'b1;
    in_tdata <= {md, imm, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cpu_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(cpu_word_t)-1:0];
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 16'h0, 16'h0);
      end else begin
        want = expected_words.pop_front();
        if (got.pc !== want.pc) report_mismatch("pc", got.pc, want.pc);
        if (got.af !== want.af) report_mismatch("af", got.af, want.af);
        if (got.bc !== want.bc) report_mismatch("bc", got.bc, want.bc);
        if (got.de !== want.de) report_mismatch("de", got.de, want.de);
        if (got.hl !== want.hl) report_mismatch("hl", got.hl, want.hl);
        if (got.sp !== want.sp) report_mismatch("sp", got.sp, want.sp);
        if (got.wkind !== want.wkind)
          report_mismatch("write_kind", 16'(got.wkind), 16'(want.wkind));
        if (got.waddr !== want.waddr) report_mismatch("write_address", got.waddr, want.waddr);
        if (got.wdata !== want.wdata) report_mismatch("write_data", got.wdata, want.wdata);
        if (got.cycles !== want.cycles)
          report_mismatch("cycle_count", 16'(got.cycles), 16'(want.cycles));
        if (got.status !== want.status)
          report_mismatch("status", 16'(got.status), 16'(want.status));
        if (out_tdata[143:$bits(cpu_word_t)] !== '0) report_mismatch("padding", 16'h0, 16'h0);
      end
      n_checked++;
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Directed: extremes, every class but INC r, LD A,(rr) and LD r,r, unsupported opcodes, flag-driven jumps, wrapping.
  task automatic test_directed();
    send_instr(OP_NOP, 16'hFFFF, 8'hFF);
    send_instr(8'h31, 16'hFFFF, 8'h00);       // LD SP,FFFF
    send_instr(8'h33, 16'h0000, 8'h00);       // INC SP wraps
    send_instr(OP_LD_NN_SP, 16'hFFFF, 8'h00);
    send_instr(8'h21, 16'hFFFF, 8'h00);       // LD HL,FFFF
    send_instr(8'h22, 16'h0000, 8'h00);       // LD (HL+),A wraps HL
    send_instr(8'h3E, 16'hFF80, 8'h00);       // LD A,80
    send_instr(OP_RLCA, 16'h0, 8'h0);
    send_instr(OP_RRA, 16'h0, 8'h0);
    send_instr(8'h3D, 16'h0, 8'h0);           // DEC A
    send_instr(8'h87, 16'h0, 8'h0);           // ADD A,A
    send_instr(8'h8E, 16'h0, 8'hFF);          // ADC A,(HL)
    send_instr(8'h96, 16'h0, 8'hFF);          // SUB (HL)
    send_instr(8'h98, 16'h0, 8'h0);           // SBC B
    send_instr(OP_JR_NZ, 16'h0080, 8'h0);
    send_instr(OP_JR_Z, 16'h007F, 8'h0);
    send_instr(OP_JR_C, 16'h00FE, 8'h0);
    send_instr(OP_JR_NC, 16'h0001, 8'h0);
    send_instr(OP_CPL, 16'h0, 8'h0);
    send_instr(OP_SCF, 16'h0, 8'h0);
    send_instr(8'h3F, 16'h0, 8'h0);           // CCF
    send_instr(8'h29, 16'h0, 8'h0);           // ADD HL,HL
    send_instr(OP_STOP, 16'hFFFF, 8'hFF);
    send_instr(OP_DAA, 16'h0, 8'h0);
    send_instr(OP_HALT, 16'h0, 8'h0);
    send_instr(8'hFF, 16'h0, 8'h0);
  endtask

  // Random instructions, weighted toward supported opcodes.
  task automatic test_random(input int count);
    logic [7:0] op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9, 0) == 0) op = 8'($urandom_range(255, 0));
      else op = 8'($urandom_range(OP_LAST, 0));
      send_instr(op, 16'($urandom_range(16'hFFFF, 0)), 8'($urandom_range(8'hFF, 0)));
    end
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits for drain.
  task automatic test_backpressure();
    in_tvalid <= 1'b0;
    @(posedge clk);
    hold_cycles <= 60;
    test_random(30);
    wait_drained();
    test_random(10);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 20; recv_idle_pct = 47;
    test_random(600);
    send_idle_pct = 47; recv_idle_pct = 20;
    test_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(560);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d instructions across all opcodes with random stalls and a long", n_sent);
    $display("receiver hold-off; %0d result words checked.", n_checked);
    if (errors == 0) $display("lr35902_instruction_execute_unit regression: pass");
    else $display("lr35902_instruction_execute_unit regression: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("lr35902_instruction_execute_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lr35902_pkg.sv
rtl/lr35902_front.sv
rtl/lr35902_queue.sv
rtl/lr35902_back.sv
rtl/lr35902_instruction_execute_unit.sv
tb/sv/tb_lr35902_instruction_execute_unit.sv
